// ----- hw/rtl/eau_pkg.sv -----
// shared types, constants and activation lookup tables for the activation unit
package eau_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CFG_FRAC  = 12;
    localparam int DATA_W    = 16;
    localparam int CFG_W     = 13;
    localparam int TAB_N     = 257;
    localparam int TAB_W     = 18;
    localparam int TAB_AW    = 9;
    localparam int IDX_W     = 8;
    localparam int SH        = FRAC_BITS - 4;
    localparam int ONE_VAL   = 1 << FRAC_BITS;

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] EXP_STEP  = 64'd1008687096;
    localparam int          RND_SHIFT = 30 - FRAC_BITS;

    localparam int T_SIG  = 0;
    localparam int T_TANH = 1;
    localparam int T_SOFT = 2;
    localparam int T_EXP  = 3;

    typedef enum logic [2:0] {
        FN_NONE     = 3'd0,
        FN_RELU     = 3'd1,
        FN_LEAKY    = 3'd2,
        FN_ELU      = 3'd3,
        FN_STEP     = 3'd4,
        FN_SIGMOID  = 3'd5,
        FN_TANH     = 3'd6,
        FN_SOFTPLUS = 3'd7
    } func_t;

    typedef enum logic {
        REG_LEAK_SLOPE = 1'b0,
        REG_ELU_ALPHA  = 1'b1
    } cfg_idx_t;

    typedef logic signed [TAB_W-1:0] tab_t [TAB_N];

    typedef struct packed {
        func_t                     func;
        logic signed [DATA_W-1:0]  value;
        logic [SH-1:0]             frac;
        logic signed [TAB_W-1:0]   lo;
        logic signed [TAB_W-1:0]   hi;
    } front_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] leak_slope;
        logic [CFG_W-1:0] elu_alpha;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // shift-subtract division, evaluated only while building the tables
    function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1+t) in q30 via 2*atanh(t/(2+t))
    function automatic logic [63:0] ln1p_q30(logic [63:0] t);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        z    = udiv(t << 30, (Q30_ONE << 1) + t);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int n = 1; n < 40; n += 2) begin
            sum  = sum + udiv(term, 64'(n));
            term = (term * z2) >> 30;
        end
        return sum << 1;
    endfunction

    function automatic logic [63:0] round_q30(logic [63:0] a);
        return (a + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    endfunction

    function automatic tab_t build_tab(int which);
        logic [63:0] e [TAB_N];
        logic [63:0] v;
        tab_t        tab;
        int          k;
        int          ak;
        e[0] = Q30_ONE;
        for (int i = 1; i < TAB_N; i++) begin
            e[i] = (e[i-1] * EXP_STEP + (Q30_ONE >> 1)) >> 30;
        end
        for (int i = 0; i < TAB_N; i++) begin
            k  = i - 128;
            ak = (k < 0) ? -k : k;
            if (which == T_SIG) begin
                v = udiv(Q30_ONE << 30, Q30_ONE + e[ak]);
                if (k < 0) begin
                    v = Q30_ONE - v;
                end
                tab[i] = TAB_W'(round_q30(v));
            end else if (which == T_TANH) begin
                v = udiv((Q30_ONE - e[2*ak]) << 30, Q30_ONE + e[2*ak]);
                v = round_q30(v);
                tab[i] = (k < 0) ? -TAB_W'(v) : TAB_W'(v);
            end else if (which == T_SOFT) begin
                v = ln1p_q30(e[ak]) + ((k > 0) ? (64'(k) << 26) : 64'd0);
                tab[i] = TAB_W'(round_q30(v));
            end else begin
                // entries above zero are never read by elu
                v = (k >= 0) ? udiv(Q30_ONE << 30, e[ak]) : e[ak];
                tab[i] = TAB_W'(round_q30(v));
            end
        end
        return tab;
    endfunction

    localparam tab_t SIG_TAB  = build_tab(T_SIG);
    localparam tab_t TANH_TAB = build_tab(T_TANH);
    localparam tab_t SOFT_TAB = build_tab(T_SOFT);
    localparam tab_t EXP_TAB  = build_tab(T_EXP);

endpackage

// ----- hw/rtl/eau_front.sv -----
// front stage: accepts items, splits the table index and reads both table neighbors
module eau_front
    import eau_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [2:0]                func,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output front_item_t               out_item
);

    logic                     valid_reg;
    front_item_t              item_reg;
    front_item_t              item_next;
    logic [DATA_W-1:0]        offs;
    logic [IDX_W-1:0]         idx;
    logic [TAB_AW-1:0]        idx_lo;
    logic [TAB_AW-1:0]        idx_hi;
    logic                     take;

    // value plus 8.0 is the sign-flipped word
    assign offs   = {~value[DATA_W-1], value[DATA_W-2:0]};
    assign idx    = offs[DATA_W-1:SH];
    assign idx_lo = {1'b0, idx};
    assign idx_hi = idx_lo + TAB_AW'(1);

    always_comb
    begin
        item_next.func  = func_t'(func);
        item_next.value = value;
        item_next.frac  = offs[SH-1:0];
        unique case (func_t'(func))
            FN_SIGMOID:
            begin
                item_next.lo = SIG_TAB[idx_lo];
                item_next.hi = SIG_TAB[idx_hi];
            end
            FN_TANH:
            begin
                item_next.lo = TANH_TAB[idx_lo];
                item_next.hi = TANH_TAB[idx_hi];
            end
            FN_SOFTPLUS:
            begin
                item_next.lo = SOFT_TAB[idx_lo];
                item_next.hi = SOFT_TAB[idx_hi];
            end
            default:
            begin
                item_next.lo = EXP_TAB[idx_lo];
                item_next.hi = EXP_TAB[idx_hi];
            end
        endcase
    end

    assign full      = valid_reg && !out_ready;
    assign take      = push && !full;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/eau_queue.sv -----
// two-entry queue between the front and back stages
module eau_queue
    import eau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    input  logic        pop,
    output front_item_t pop_item,
    output q_stat_t     stat
);

    front_item_t mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/eau_back.sv -----
// back stages: interpolation and slope products, then elu scale, select, saturate, output queue
module eau_back
    import eau_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    input  front_item_t               in_item,
    output logic                      in_ready,
    output logic signed [DATA_W-1:0]  result,
    output logic                      empty,
    input  logic                      pop
);

    localparam int D_W  = TAB_W + 1;
    localparam int P_W  = D_W + SH + 1;
    localparam int T_W  = 20;
    localparam int LP_W = DATA_W + CFG_W + 1;
    localparam int EP_W = T_W + CFG_W + 1;
    localparam int Y_W  = 22;

    // interpolation and leaky product stage
    logic                      b1_valid_reg;
    func_t                     b1_func_reg;
    logic signed [DATA_W-1:0]  b1_value_reg;
    logic signed [T_W-1:0]     b1_interp_reg;
    logic signed [T_W-1:0]     b1_leaky_reg;

    logic signed [D_W-1:0]     diff;
    logic signed [P_W-1:0]     prod;
    logic signed [P_W-1:0]     prod_shift;
    logic signed [T_W-1:0]     interp_next;
    logic signed [LP_W-1:0]    lprod;
    logic signed [LP_W-1:0]    lprod_shift;
    logic                      b1_take;
    logic                      b1_ready;

    assign diff        = D_W'(in_item.hi) - D_W'(in_item.lo);
    assign prod        = P_W'(diff) * P_W'($signed({1'b0, in_item.frac}));
    assign prod_shift  = (prod + P_W'(1 << (SH - 1))) >>> SH;
    assign interp_next = T_W'(in_item.lo) + T_W'(prod_shift);
    assign lprod       = LP_W'(in_item.value) * LP_W'($signed({1'b0, cfg.leak_slope}));
    assign lprod_shift = (lprod + LP_W'(1 << (CFG_FRAC - 1))) >>> CFG_FRAC;

    // output queue
    logic signed [DATA_W-1:0]  oq_mem [2];
    logic                      oq_wr_reg;
    logic                      oq_rd_reg;
    logic [1:0]                oq_count_reg;
    logic                      oq_full;
    logic                      oq_push;
    logic                      oq_pop;

    assign oq_full  = (oq_count_reg == 2'd2);
    assign empty    = (oq_count_reg == 2'd0);
    assign oq_pop   = pop && !empty;
    assign result   = oq_mem[oq_rd_reg];

    assign b1_ready = !b1_valid_reg || !oq_full;
    assign oq_push  = b1_valid_reg && !oq_full;
    assign in_ready = b1_ready;
    assign b1_take  = in_valid && b1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (b1_ready)
        begin
            b1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_take)
        begin
            b1_func_reg   <= in_item.func;
            b1_value_reg  <= in_item.value;
            b1_interp_reg <= interp_next;
            b1_leaky_reg  <= T_W'(lprod_shift);
        end
    end

    // elu scale, function select and saturation
    logic signed [T_W-1:0]     em1;
    logic signed [EP_W-1:0]    eprod;
    logic signed [EP_W-1:0]    eprod_shift;
    logic signed [Y_W-1:0]     vx;
    logic signed [Y_W-1:0]     y;
    logic signed [DATA_W-1:0]  y_sat;
    logic                      neg;

    assign em1         = b1_interp_reg - T_W'(ONE_VAL);
    assign eprod       = EP_W'(em1) * EP_W'($signed({1'b0, cfg.elu_alpha}));
    assign eprod_shift = (eprod + EP_W'(1 << (CFG_FRAC - 1))) >>> CFG_FRAC;
    assign vx          = Y_W'(b1_value_reg);
    assign neg         = b1_value_reg[DATA_W-1];

    always_comb
    begin
        unique case (b1_func_reg)
            FN_NONE:     y = vx;
            FN_RELU:     y = neg ? '0 : vx;
            FN_LEAKY:    y = neg ? Y_W'(b1_leaky_reg) : vx;
            FN_ELU:      y = neg ? Y_W'(eprod_shift) : vx;
            FN_STEP:     y = neg ? '0 : Y_W'(ONE_VAL);
            FN_SIGMOID:  y = Y_W'(b1_interp_reg);
            FN_TANH:     y = Y_W'(b1_interp_reg);
            FN_SOFTPLUS: y = Y_W'(b1_interp_reg);
            default:     y = vx;
        endcase
    end

    always_comb
    begin
        priority if (y > Y_W'(32767))
        begin
            y_sat = 16'sh7fff;
        end
        else if (y < -Y_W'(32768))
        begin
            y_sat = -16'sh8000;
        end
        else
        begin
            y_sat = DATA_W'(y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_push && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + 2'd1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_count_reg <= oq_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= y_sat;
        end
    end

endmodule

// ----- hw/rtl/elementwise_activation_unit.sv -----
// activation unit top level: slope registers, front stage, queue and back stages
// path: front register, mid queue, b1 register, output queue, then empty low
// throughput: one transaction per cycle while results are popped, set by the
// front table read and the two-deep queues on either side of the back stages
// reset: rst_n asynchronous active low; empties all queues and stages,
// leak_slope and elu_alpha return to 0.5
module elementwise_activation_unit
    import eau_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [2:0]                func,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [DATA_W-1:0]  result
);

    logic [CFG_W-1:0] leak_slope_reg;
    logic [CFG_W-1:0] elu_alpha_reg;
    cfg_t             cfg;

    logic             f_valid;
    logic             f_ready;
    front_item_t      f_item;
    front_item_t      q_item;
    q_stat_t          q_stat;
    logic             b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_slope_reg <= CFG_W'(2048);
            elu_alpha_reg  <= CFG_W'(2048);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LEAK_SLOPE: leak_slope_reg <= cfg_data;
                REG_ELU_ALPHA:  elu_alpha_reg  <= cfg_data;
                default:        leak_slope_reg <= leak_slope_reg;
            endcase
        end
    end

    assign cfg.leak_slope = leak_slope_reg;
    assign cfg.elu_alpha  = elu_alpha_reg;
    assign f_ready        = !q_stat.full;

    eau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .value     (value),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    eau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .pop       (b_ready),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    eau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (!q_stat.empty),
        .in_item  (q_item),
        .in_ready (b_ready),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("mid queue reports full and empty together");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> f_valid)
        else $error("accepted transaction not held in front stage");

    a_leak_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_LEAK_SLOPE) |=> leak_slope_reg == $past(cfg_data))
        else $error("leak slope write lost");
`endif

endmodule

// ----- verif/eau_checker.sv -----
// checker for the activation unit: tracks the slope registers, predicts and compares results
`timescale 1ns / 1ps
module eau_checker
    import eau_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      push,
    input  logic                      full,
    input  logic [2:0]                func,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      empty,
    input  logic                      pop,
    input  logic signed [DATA_W-1:0]  result,
    output int                        errors,
    output int                        pending
);

    longint                    lut [4][TAB_N];
    logic [CFG_W-1:0]          leak_q;
    logic [CFG_W-1:0]          alpha_q;
    logic signed [DATA_W-1:0]  act_expected [$];

    function automatic logic [63:0] log1p_fixed(logic [63:0] t);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        z    = (t << 30) / ((64'd1 << 31) + t);
        z2   = (z * z) >> 30;
        term = z;
        acc  = 0;
        for (int n = 1; n < 40; n += 2)
        begin
            acc  = acc + term / 64'(n);
            term = (term * z2) >> 30;
        end
        return acc << 1;
    endfunction

    function automatic longint to_q12(logic [63:0] a);
        return longint'((a + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    endfunction

    function automatic longint floor_div(longint a, int s);
        if (a >= 0)
            return a >>> s;
        return -((-a + (longint'(1) << s) - 1) >>> s);
    endfunction

    function automatic longint interp(int w, longint v);
        longint lim;
        longint u;
        longint idx;
        longint fr;
        longint d;
        lim = longint'(8) << FRAC_BITS;
        if (v >= lim)
            return lut[w][TAB_N-1];
        if (v < -lim)
            return lut[w][0];
        u   = v + lim;
        idx = u >>> SH;
        fr  = u & ((longint'(1) << SH) - 1);
        d   = lut[w][idx+1] - lut[w][idx];
        return lut[w][idx] + floor_div(d * fr + (longint'(1) << (SH - 1)), SH);
    endfunction

    function automatic logic signed [DATA_W-1:0] activate(func_t f, longint v);
        longint one;
        longint y;
        one = longint'(1) << FRAC_BITS;
        case (f)
            FN_RELU:     y = (v < 0) ? 0 : v;
            FN_LEAKY:    y = (v < 0) ? floor_div(v * longint'(leak_q) + 2048, 12) : v;
            FN_ELU:      y = (v < 0) ?
                             floor_div((interp(T_EXP, v) - one) * longint'(alpha_q) + 2048, 12)
                             : v;
            FN_STEP:     y = (v < 0) ? 0 : one;
            FN_SIGMOID:  y = interp(T_SIG, v);
            FN_TANH:     y = interp(T_TANH, v);
            FN_SOFTPLUS: y = (v >= (longint'(8) << FRAC_BITS)) ? v : interp(T_SOFT, v);
            default:     y = v;
        endcase
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return DATA_W'(y);
    endfunction

    initial
    begin
        logic [63:0] e [TAB_N];
        logic [63:0] q;
        int          k;
        int          ak;
        e[0] = 64'd1 << 30;
        for (int i = 1; i < TAB_N; i++)
            e[i] = (e[i-1] * 64'd1008687096 + (64'd1 << 29)) >> 30;
        for (int i = 0; i < TAB_N; i++)
        begin
            k  = i - 128;
            ak = (k < 0) ? -k : k;
            q  = (64'd1 << 60) / ((64'd1 << 30) + e[ak]);
            if (k < 0)
                q = (64'd1 << 30) - q;
            lut[T_SIG][i] = to_q12(q);
            q = (((64'd1 << 30) - e[2*ak]) << 30) / ((64'd1 << 30) + e[2*ak]);
            lut[T_TANH][i] = (k < 0) ? -to_q12(q) : to_q12(q);
            lut[T_SOFT][i] = to_q12(log1p_fixed(e[ak]) + ((k > 0) ? (64'(k) << 26) : 64'd0));
            q = (k >= 0) ? (64'd1 << 60) / e[ak] : e[ak];
            lut[T_EXP][i] = to_q12(q);
        end
    end

    assign pending = act_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [DATA_W-1:0] want;
        if (!rst_n)
        begin
            leak_q  <= 13'd2048;
            alpha_q <= 13'd2048;
            act_expected.delete();
            errors  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx_t'(cfg_index) == REG_LEAK_SLOPE)
                    leak_q <= cfg_data;
                else
                    alpha_q <= cfg_data;
            end
            if (pop && !empty)
            begin
                if (act_expected.size() == 0)
                begin
                    $error("result transaction with nothing expected: result=%0d", result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = act_expected.pop_front();
                    if (result !== want)
                    begin
                        $error("result mismatch: expected %0d, actual %0d", want, result);
                        errors <= errors + 1;
                    end
                end
            end
            // config writes only happen while idle, so current registers apply
            if (push && !full)
                act_expected.push_back(activate(func_t'(func), longint'(value)));
        end
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the activation unit: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb
    import eau_pkg::*;
();

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      push;
    logic                      full;
    logic [2:0]                func;
    logic signed [DATA_W-1:0]  value;
    logic                      empty;
    logic                      pop;
    logic signed [DATA_W-1:0]  result;
    int                        errors;
    int                        pending;
    int                        quiet_cycles;

    elementwise_activation_unit uut (.*);

    eau_checker chk (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 2000)
        begin
            $display("** elementwise_activation_unit: FAILED **");
            $finish;
        end
    end

    // result side: random stall before each pop
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    task automatic send(func_t f, logic signed [DATA_W-1:0] v, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        func  <= f;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slopes(logic [CFG_W-1:0] leak, logic [CFG_W-1:0] alpha);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LEAK_SLOPE;
        cfg_data  <= leak;
        @(posedge clk);
        cfg_index <= REG_ELU_ALPHA;
        cfg_data  <= alpha;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int n);
        bit burst;
        logic signed [DATA_W-1:0] v;
        burst = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 5))
                0:       v = 16'($urandom_range(0, 65535));
                1:       v = 16'(-$signed(17'($urandom_range(0, 4096))));
                2:       v = 16'($urandom_range(0, 4096));
                3:       v = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
                default: v = 16'($urandom);
            endcase
            send(func_t'($urandom_range(0, 7)), v, burst);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LEAK_SLOPE;
        cfg_data  = '0;
        push      = 1'b0;
        func      = FN_NONE;
        value     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of every function at reset slopes, then the sign boundary cases
        for (int f = 0; f < 8; f++)
        begin
            send(func_t'(f), 16'sh8000, 1'b0);
            send(func_t'(f), 16'sh7fff, 1'b0);
        end
        send(FN_STEP, 16'sd0, 1'b0);
        send(FN_STEP, -16'sd1, 1'b0);
        send(FN_RELU, -16'sd1, 1'b1);
        send(FN_LEAKY, -16'sd1, 1'b1);
        send(FN_ELU, -16'sd1, 1'b0);
        send(FN_SIGMOID, 16'sd0, 1'b0);
        send(FN_TANH, 16'sd0, 1'b1);
        send(FN_SOFTPLUS, 16'sd1, 1'b0);
        random_items(120);
        drain();

        write_slopes(13'd0, 13'd0);
        random_items(110);
        drain();
        write_slopes(13'd4096, 13'd4096);
        random_items(110);
        drain();
        // factors beyond one, leaky results can saturate
        write_slopes(13'h1fff, 13'h1fff);
        random_items(110);
        drain();
        write_slopes(13'd1, 13'd4095);
        random_items(110);
        drain();
        write_slopes(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        random_items(110);
        drain();
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("** elementwise_activation_unit: PASSED **");
        else
            $display("** elementwise_activation_unit: FAILED **");
        $finish;
    end

endmodule
